### src/drdda_pkg.sv
// Shared types, constants and log/exp lookup tables for the degree-day accumulator.
// No dependencies; every other file imports this package.
package drdda_pkg;

    localparam int LOG_TABLE_BITS = 8;
    localparam int FRAC_BITS      = 16;
    localparam int LOG_FRAC       = 28;
    localparam int TBL_N          = 1 << LOG_TABLE_BITS;
    localparam int TBL_SIZE       = TBL_N + 1;
    localparam int TBL_IDX_W      = LOG_TABLE_BITS + 1;
    localparam int REM_W          = LOG_FRAC - LOG_TABLE_BITS;
    localparam int TBL_VAL_W      = LOG_FRAC + 1;
    localparam int LOGMAG_W       = LOG_FRAC + 5;
    localparam int POW_W          = FRAC_BITS + 1;
    localparam int MUL_A_W        = 34;
    localparam int MUL_B_W        = 20;
    localparam int MUL_P_W        = MUL_A_W + MUL_B_W;
    localparam int TOTAL_W        = 48;
    localparam int INC_W          = 32;
    localparam int EXP_SHIFT_W    = 10;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_LOWER = 3'd0;
    localparam logic [2:0] REG_UPPER = 3'd1;
    localparam logic [2:0] REG_SCALE = 3'd2;
    localparam logic [2:0] REG_RISE  = 3'd3;
    localparam logic [2:0] REG_FALL  = 3'd4;
    localparam logic [2:0] REG_STEP  = 3'd5;

    typedef struct packed {
        logic signed [15:0] lower_threshold;
        logic signed [15:0] upper_limit;
        logic [15:0]        scale_factor;
        logic [15:0]        exponent_rise;
        logic [15:0]        exponent_fall;
        logic [15:0]        step_length;
    } cfg_t;

    typedef struct packed {
        logic             done;
        logic             idle;
        logic [INC_W-1:0] increment;
    } core_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_POW,
        ST_LOGF,
        ST_BMUL,
        ST_EXPI,
        ST_EXPF,
        ST_PROD,
        ST_SCALE,
        ST_STEP,
        ST_FIN,
        ST_DONE
    } core_state_t;

    typedef logic [31:0] tbl_t [TBL_SIZE];

    // log2(1 + i/N) by repeated squaring, LOG_FRAC fraction bits
    function automatic tbl_t make_log_tbl();
        tbl_t        t;
        logic [63:0] z;
        logic [31:0] acc;
        for (int i = 0; i < TBL_N; i++) begin
            z   = (64'd1 << 31) + (64'(i) << (31 - LOG_TABLE_BITS));
            acc = '0;
            for (int k = 0; k < LOG_FRAC; k++) begin
                z   = (z * z) >> 31;
                acc = acc << 1;
                if (z >= (64'd1 << 32)) begin
                    z   = z >> 1;
                    acc = acc | 32'd1;
                end
            end
            t[i] = acc;
        end
        t[TBL_N] = 32'd1 << LOG_FRAC;
        return t;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v   = v_in;
        res = '0;
        bt  = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bt > v) bt = bt >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (bt != 0) begin
                if (v >= res + bt) begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end
                else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-i/N) as a product of truncated root constants, LOG_FRAC fraction bits
    function automatic tbl_t make_exp_tbl();
        tbl_t        t;
        logic [63:0] roots [LOG_TABLE_BITS+1];
        logic [63:0] prod;
        roots[0] = 64'd1 << 29;
        for (int k = 1; k <= LOG_TABLE_BITS; k++) begin
            roots[k] = isqrt64(roots[k-1] << 30);
        end
        for (int i = 0; i < TBL_SIZE; i++) begin
            prod = 64'd1 << 30;
            for (int j = 0; j <= LOG_TABLE_BITS; j++) begin
                if (((i >> j) & 1) != 0) prod = (prod * roots[LOG_TABLE_BITS-j]) >> 30;
            end
            t[i] = 32'(prod >> 2);
        end
        return t;
    endfunction

    localparam tbl_t LOG_TBL = make_log_tbl();
    localparam tbl_t EXP_TBL = make_exp_tbl();

endpackage

### src/development_rate_degree_day_accumulator.sv
// Top level: configuration registers, input/output handshake and the saturating total.
// Depends on drdda_pkg and drdda_core.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  input    | in_valid / in_ready    | temperature, clear_total, ticking
//  output   | out_valid / out_ready  | increment, total_out
//  config   | psel penable pwrite    | paddr, pwdata, prdata (pready = 1)
//
// The 17-step divider and the single shared multiplier, used up to nine times
// per item, set how long an item takes. The core holds one item at a time;
// the output register can hold one more.
// rst_n clears the state machine, the output valid, the total and the
// configuration registers to their defaults. A stalled output register holds
// its item while the next item is already being worked on.
module development_rate_degree_day_accumulator
    import drdda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] temperature,
    input  logic               clear_total,
    input  logic               ticking,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [INC_W-1:0]   increment,
    output logic [TOTAL_W-1:0] total_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t               cfg_reg;
    logic               clear_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               out_valid_reg;
    logic [INC_W-1:0]   out_inc_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               start;
    logic               res_take;
    logic               cfg_wr;
    logic [2:0]         reg_idx;
    logic [TOTAL_W:0]   sum;
    core_res_t          res;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[4:2];
    assign cfg_wr   = psel && penable && pwrite;
    assign in_ready = res.idle;
    assign start    = in_valid && in_ready;
    // advance a finished result when the output register is empty or draining
    assign res_take = res.done && (!out_valid_reg || out_ready);

    drdda_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .temperature (temperature),
        .ticking     (ticking),
        .cfg         (cfg_reg),
        .res_take    (res_take),
        .res         (res)
    );

    // Clear drops the old total before the increment goes in; saturate at all ones
    always_comb
    begin
        sum = (clear_reg ? '0 : {1'b0, total_reg}) + (TOTAL_W+1)'(res.increment);
        total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower_threshold <= 16'sd2048;
            cfg_reg.upper_limit     <= '0;
            cfg_reg.scale_factor    <= '0;
            cfg_reg.exponent_rise   <= '0;
            cfg_reg.exponent_fall   <= '0;
            cfg_reg.step_length     <= 16'd256;
            total_reg               <= '0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (reg_idx)
                    REG_LOWER: cfg_reg.lower_threshold <= pwdata[15:0];
                    REG_UPPER: cfg_reg.upper_limit     <= pwdata[15:0];
                    REG_SCALE: cfg_reg.scale_factor    <= pwdata[15:0];
                    REG_RISE:  cfg_reg.exponent_rise   <= pwdata[15:0];
                    REG_FALL:  cfg_reg.exponent_fall   <= pwdata[15:0];
                    REG_STEP:  cfg_reg.step_length     <= pwdata[15:0];
                    default:   ;
                endcase
            end
            if (res_take)
            begin
                total_reg     <= total_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture clear at accept, result at hand-off
    always_ff @(posedge clk)
    begin
        if (start) clear_reg <= clear_total;
        if (res_take)
        begin
            out_inc_reg   <= res.increment;
            out_total_reg <= total_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_LOWER: prdata = {16'b0, cfg_reg.lower_threshold};
            REG_UPPER: prdata = {16'b0, cfg_reg.upper_limit};
            REG_SCALE: prdata = {16'b0, cfg_reg.scale_factor};
            REG_RISE:  prdata = {16'b0, cfg_reg.exponent_rise};
            REG_FALL:  prdata = {16'b0, cfg_reg.exponent_fall};
            REG_STEP:  prdata = {16'b0, cfg_reg.step_length};
            default:   prdata = '0;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign increment = out_inc_reg;
    assign total_out = out_total_reg;

endmodule

### src/drdda_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on drdda_pkg for operand widths.
module drdda_mul
    import drdda_pkg::*;
(
    input  logic               clk,
    input  logic [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0] op_b,
    output logic [MUL_P_W-1:0] prod
);

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

### src/drdda_core.sv
// Sequencer for one item: divide, two powers via table log/exp, and the scale products.
// Depends on drdda_pkg and drdda_mul.
module drdda_core
    import drdda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] temperature,
    input  logic               ticking,
    input  cfg_t               cfg,
    input  logic               res_take,
    output core_res_t          res
);

    core_state_t state_reg, state_next;

    logic [15:0]          d_reg, d_next;
    logic [15:0]          r_reg, r_next;
    logic [17:0]          rem_reg, rem_next;
    logic [POW_W-1:0]     quo_reg, quo_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 pass_reg, pass_next;
    logic [TBL_VAL_W-1:0] lo_reg, lo_next;
    logic                 up_reg, up_next;
    logic [4:0]           p_reg, p_next;
    logic [LOGMAG_W-1:0]  logmag_reg, logmag_next;
    logic [8:0]           q_reg, q_next;
    logic [POW_W-1:0]     xn_reg, xn_next;
    logic [POW_W-1:0]     ym_reg, ym_next;
    logic [INC_W-1:0]     inc_reg, inc_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;

    logic signed [16:0]   d_full, r_full;
    logic                 item_ok;
    logic [17:0]          div_diff;
    logic                 div_ge;
    logic [POW_W-1:0]     pow_v;
    logic [15:0]          pow_e;
    logic [4:0]           msb;
    logic [44:0]          w_full;
    logic [LOG_FRAC-1:0]  tfrac;
    logic [LOG_TABLE_BITS-1:0] tidx;
    logic [TBL_VAL_W-1:0] ta, tb, tdiff;
    logic [36:0]          bq;
    logic [TBL_VAL_W-1:0] istep, ival;
    logic [EXP_SHIFT_W-1:0] esh;
    logic [POW_W-1:0]     pw;

    drdda_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    function automatic logic [4:0] msb_index(input logic [POW_W-1:0] v);
        logic [4:0] m;
        m = '0;
        for (int i = 0; i < POW_W; i++) begin
            if (v[i]) m = 5'(i);
        end
        return m;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        r_reg      <= r_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        pass_reg   <= pass_next;
        lo_reg     <= lo_next;
        up_reg     <= up_next;
        p_reg      <= p_next;
        logmag_reg <= logmag_next;
        q_reg      <= q_next;
        xn_reg     <= xn_next;
        ym_reg     <= ym_next;
        inc_reg    <= inc_next;
    end

    always_comb
    begin
        d_full  = 17'(temperature) - 17'(cfg.lower_threshold);
        r_full  = 17'(cfg.upper_limit) - 17'(cfg.lower_threshold);
        item_ok = ticking && (r_full > 0) && (d_full > 0) && (d_full <= r_full);

        div_ge   = rem_reg >= {2'b0, r_reg};
        div_diff = div_ge ? (rem_reg - {2'b0, r_reg}) : rem_reg;

        pow_v  = pass_reg ? (POW_W'(1) << FRAC_BITS) - quo_reg : quo_reg;
        pow_e  = pass_reg ? cfg.exponent_fall : cfg.exponent_rise;
        msb    = msb_index(pow_v);
        w_full = 45'(pow_v) << (5'(LOG_FRAC) - msb);
        bq     = prod[48:12];

        // Interpolation front end serves both the log and the exp lookup
        if (state_reg == ST_POW)
        begin
            tfrac = w_full[LOG_FRAC-1:0];
            tidx  = tfrac[LOG_FRAC-1:REM_W];
            ta    = LOG_TBL[{1'b0, tidx}][TBL_VAL_W-1:0];
            tb    = LOG_TBL[TBL_IDX_W'(tidx) + TBL_IDX_W'(1)][TBL_VAL_W-1:0];
        end
        else
        begin
            tfrac = bq[LOG_FRAC-1:0];
            tidx  = tfrac[LOG_FRAC-1:REM_W];
            ta    = EXP_TBL[{1'b0, tidx}][TBL_VAL_W-1:0];
            tb    = EXP_TBL[TBL_IDX_W'(tidx) + TBL_IDX_W'(1)][TBL_VAL_W-1:0];
        end
        tdiff = (tb >= ta) ? tb - ta : ta - tb;

        istep = prod[REM_W+TBL_VAL_W-1:REM_W];
        ival  = up_reg ? lo_reg + istep : lo_reg - istep;
        esh   = EXP_SHIFT_W'(LOG_FRAC - FRAC_BITS) + EXP_SHIFT_W'(q_reg);
        pw    = (esh >= EXP_SHIFT_W'(64)) ? '0 : POW_W'(ival >> esh[5:0]);
    end

    always_comb
    begin
        state_next  = state_reg;
        d_next      = d_reg;
        r_next      = r_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        pass_next   = pass_reg;
        lo_next     = lo_reg;
        up_next     = up_reg;
        p_next      = p_reg;
        logmag_next = logmag_reg;
        q_next      = q_reg;
        xn_next     = xn_reg;
        ym_next     = ym_reg;
        inc_next    = inc_reg;
        mul_a       = '0;
        mul_b       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    d_next   = d_full[15:0];
                    r_next   = r_full[15:0];
                    rem_next = {2'b0, d_full[15:0]};
                    quo_next = '0;
                    cnt_next = 5'(FRAC_BITS);
                    pass_next = 1'b0;
                    inc_next = '0;
                    state_next = item_ok ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                quo_next = {quo_reg[POW_W-2:0], div_ge};
                rem_next = {div_diff[16:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0) state_next = ST_POW;
            end
            ST_POW:
            begin
                if (pow_e == '0 || pow_v == '0)
                begin
                    if (pass_reg) ym_next = (pow_e == '0) ? POW_W'(1) << FRAC_BITS : '0;
                    else          xn_next = (pow_e == '0) ? POW_W'(1) << FRAC_BITS : '0;
                    pass_next  = 1'b1;
                    state_next = pass_reg ? ST_PROD : ST_POW;
                end
                else
                begin
                    lo_next    = ta;
                    up_next    = tb >= ta;
                    p_next     = msb;
                    mul_a      = MUL_A_W'(tdiff);
                    mul_b      = MUL_B_W'(tfrac[REM_W-1:0]);
                    state_next = ST_LOGF;
                end
            end
            ST_LOGF:
            begin
                logmag_next = (LOGMAG_W'(5'(FRAC_BITS) - p_reg) << LOG_FRAC)
                              - LOGMAG_W'(ival);
                state_next  = ST_BMUL;
            end
            ST_BMUL:
            begin
                mul_a      = MUL_A_W'(logmag_reg);
                mul_b      = MUL_B_W'(pow_e);
                state_next = ST_EXPI;
            end
            ST_EXPI:
            begin
                q_next     = bq[36:LOG_FRAC];
                lo_next    = ta;
                up_next    = tb >= ta;
                mul_a      = MUL_A_W'(tdiff);
                mul_b      = MUL_B_W'(tfrac[REM_W-1:0]);
                state_next = ST_EXPF;
            end
            ST_EXPF:
            begin
                if (pass_reg) ym_next = pw;
                else          xn_next = pw;
                pass_next  = 1'b1;
                state_next = pass_reg ? ST_PROD : ST_POW;
            end
            ST_PROD:
            begin
                mul_a      = MUL_A_W'(xn_reg);
                mul_b      = MUL_B_W'(ym_reg);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mul_a      = MUL_A_W'(prod[2*FRAC_BITS:FRAC_BITS]);
                mul_b      = MUL_B_W'(cfg.scale_factor);
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                mul_a      = MUL_A_W'(prod[32:0]);
                mul_b      = MUL_B_W'(cfg.step_length);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                inc_next   = prod[FRAC_BITS+INC_W-1:FRAC_BITS];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take) state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.done      = (state_reg == ST_DONE);
    assign res.idle      = (state_reg == ST_IDLE);
    assign res.increment = inc_reg;

endmodule
